>>> sv/srrq_pkg.sv
// Shared types and operation codes for the sharded round-robin queue.
package srrq_pkg;

  // Data word carried by the queues.
  typedef logic signed [31:0] word_t;

  // Operation codes on the mode field.
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // Width of the reported shard index.
  localparam int unsigned SHARD_USED_W = 3;

endpackage

>>> sv/sharded_round_robin_queue_unit.sv
// Sharded round-robin queue: SHARDS bounded FIFOs in one storage memory.
//
// Each request is a push or a pop and yields exactly one response. Pushes go to
// the shards in turn. A pop serves the first non-empty shard at or after the
// shard of the last successful pop. Requests are handled one at a time. A push
// to a full shard, or a pop with every shard empty, goes from accept straight
// to ST_DONE. A normal push passes through ST_META, where the pointers read at
// accept are updated. A normal pop passes through ST_META and then ST_DATA for
// the storage read. A new request is taken as soon as the previous one has
// moved into the output register, even while that response is still stalled.
// Per-shard empty/full flags and a valid bit per pointer entry live in
// flip-flops, so no clearing pass follows reset.
module sharded_round_robin_queue_unit #(
  parameter int unsigned SHARDS = 8,
  parameter int unsigned DEPTH  = 16
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  // request channel
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic                                    mode_i,
  input  srrq_pkg::word_t                         push_value_i,
  // response channel
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output srrq_pkg::word_t                         pop_value_o,
  output logic                                    found_o,
  output logic                                    dropped_o,
  output logic [srrq_pkg::SHARD_USED_W-1:0]       shard_used_o
);
  import srrq_pkg::*;

  localparam int unsigned SW = $clog2(SHARDS);
  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned AW = $clog2(SHARDS * DEPTH);
  localparam logic [SW-1:0] LAST_SHARD = SW'(SHARDS - 1);
  localparam logic [PW-1:0] LAST_PTR   = PW'(DEPTH - 1);
  localparam logic [AW-1:0] DEPTH_A    = AW'(DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_META,
    ST_DATA,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [PW-1:0] head;
    logic [PW-1:0] tail;
  } meta_t;

  // Memories
  word_t st_mem   [SHARDS*DEPTH];
  meta_t meta_mem [SHARDS];

  // Control state
  state_e        state_q;
  logic [SW-1:0] push_sel_q;
  logic [SW-1:0] scan_start_q;
  logic [SHARDS-1:0] nonempty_q;
  logic [SHARDS-1:0] full_q;
  logic [SHARDS-1:0] meta_vld_q;
  logic          out_valid_q;

  // Request and result holding registers
  logic          op_q;
  logic [SW-1:0] shard_q;
  word_t         push_value_q;
  word_t         res_value_q;
  logic          res_found_q;
  logic          res_drop_q;
  word_t         out_value_q;
  logic          out_found_q;
  logic          out_drop_q;
  logic [SW-1:0] out_shard_q;

  // Memory read data
  meta_t         meta_rd_q;
  logic          meta_rd_vld_q;
  word_t         st_rdata_q;

  logic          in_accept;
  logic          out_free;

  // Rotating priority encoder over the non-empty flags
  logic [SHARDS-1:0] hi_ne;
  logic [SHARDS-1:0] pick;
  logic [SHARDS-1:0] pick_one;
  logic [SW-1:0]     pop_sel;
  logic              any_ne;

  logic [SW-1:0] sel_shard;
  logic          sel_trivial;

  meta_t         meta_cur;
  logic [PW-1:0] head_nxt;
  logic [PW-1:0] tail_nxt;
  logic [AW-1:0] st_addr;
  logic          st_we;
  logic          st_re;

  assign in_accept  = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;

  // Pick the first non-empty shard at or after the scan start, else wrap
  always_comb begin
    hi_ne    = nonempty_q & ({SHARDS{1'b1}} << scan_start_q);
    pick     = (hi_ne != '0) ? hi_ne : nonempty_q;
    pick_one = pick & (~pick + SHARDS'(1));
    any_ne   = (nonempty_q != '0);
    pop_sel  = '0;
    for (int i = 0; i < SHARDS; i++) begin
      if (pick_one[i]) begin
        pop_sel = pop_sel | SW'(i);
      end
    end
  end

  // Choose the shard and spot requests that need no memory access
  always_comb begin
    if (mode_i == OP_POP) begin
      sel_shard   = pop_sel;
      sel_trivial = !any_ne;
    end else begin
      sel_shard   = push_sel_q;
      sel_trivial = full_q[push_sel_q];
    end
  end

  // Pointer update and storage access for the latched request
  always_comb begin
    meta_cur = meta_rd_vld_q ? meta_rd_q : '0;
    head_nxt = (meta_cur.head == LAST_PTR) ? '0 : meta_cur.head + PW'(1);
    tail_nxt = (meta_cur.tail == LAST_PTR) ? '0 : meta_cur.tail + PW'(1);
    st_we    = (state_q == ST_META) && (op_q == OP_PUSH);
    st_re    = (state_q == ST_META) && (op_q == OP_POP);
    st_addr  = AW'(shard_q) * DEPTH_A
             + AW'((op_q == OP_PUSH) ? meta_cur.tail : meta_cur.head);
  end

  // Storage memory: one port, read or write
  always_ff @(posedge clk_i) begin
    if (st_we) begin
      st_mem[st_addr] <= push_value_q;
    end
    if (st_re) begin
      st_rdata_q <= st_mem[st_addr];
    end
  end

  // Pointer memory: read at accept, written back in ST_META
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      meta_rd_q <= meta_mem[sel_shard];
    end
    if (state_q == ST_META) begin
      meta_mem[shard_q] <= (op_q == OP_PUSH) ? meta_t'{meta_cur.head, tail_nxt}
                                             : meta_t'{head_nxt, meta_cur.tail};
    end
  end

  // Sequencer, flags and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      push_sel_q   <= '0;
      scan_start_q <= '0;
      nonempty_q   <= '0;
      full_q       <= '0;
      meta_vld_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      // drop a response once taken, unless a new one loads
      if (out_valid_q && !out_stall_i && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            op_q          <= mode_i;
            shard_q       <= sel_shard;
            push_value_q  <= push_value_i;
            meta_rd_vld_q <= meta_vld_q[sel_shard];
            res_value_q   <= '0;
            res_found_q   <= 1'b0;
            res_drop_q    <= (mode_i == OP_PUSH) && sel_trivial;
            if (mode_i == OP_PUSH) begin
              push_sel_q <= (push_sel_q == LAST_SHARD) ? '0 : push_sel_q + SW'(1);
            end
            state_q <= sel_trivial ? ST_DONE : ST_META;
          end
        end
        ST_META: begin
          meta_vld_q[shard_q] <= 1'b1;
          if (op_q == OP_PUSH) begin
            nonempty_q[shard_q] <= 1'b1;
            full_q[shard_q]     <= (tail_nxt == meta_cur.head);
            state_q             <= ST_DONE;
          end else begin
            nonempty_q[shard_q] <= (head_nxt != meta_cur.tail);
            full_q[shard_q]     <= 1'b0;
            scan_start_q        <= shard_q;
            state_q             <= ST_DATA;
          end
        end
        ST_DATA: begin
          res_value_q <= st_rdata_q;
          res_found_q <= 1'b1;
          state_q     <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_value_q <= res_value_q;
            out_found_q <= res_found_q;
            out_drop_q  <= res_drop_q;
            // a pop that found nothing reports shard zero
            out_shard_q <= ((op_q == OP_POP) && !res_found_q) ? '0 : shard_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pop_value_o  = out_value_q;
  assign found_o      = out_found_q;
  assign dropped_o    = out_drop_q;
  assign shard_used_o = SHARD_USED_W'(out_shard_q);

  // A full shard is never flagged empty
  a_full_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (full_q & ~nonempty_q) == '0)
    else $error("full shard flagged empty");

  // An accepted request always leaves the idle state
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q != ST_IDLE))
    else $error("request accepted without starting");

  // The storage read cycle always follows a pointer update
  a_data_after_meta: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DATA) |-> ($past(state_q) == ST_META))
    else $error("storage read out of sequence");

  // A response never reports both found and dropped
  a_found_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_found_q && out_drop_q))
    else $error("response both found and dropped");

endmodule
